// ===== rtl/jacs_pkg.sv =====
// Shared types and constants of the joystick axis calibrated scaler.
`timescale 1ns / 1ps
package jacs_pkg;

  localparam int unsigned QBITS = 15;
  localparam int unsigned LAT   = 2 + QBITS;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned POS_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_MID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MID  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 3'd5;

  localparam logic [CFG_W-1:0] RST_LOW  = 16'd32768;
  localparam logic [CFG_W-1:0] RST_MID  = 16'd49152;
  localparam logic [CFG_W-1:0] RST_HIGH = 16'd65535;

  localparam logic [POS_W-1:0] POS_ZERO   = 16'd0;
  localparam logic [POS_W-1:0] POS_FULL   = 16'd65535;
  localparam logic [POS_W-1:0] POS_CENTER = 16'd32767;

  typedef enum logic [1:0] {
    SEG_ZERO = 2'd0,
    SEG_FULL = 2'd1,
    SEG_LOW  = 2'd2,
    SEG_HIGH = 2'd3
  } seg_t;

endpackage

// ===== rtl/jacs_in_if.sv =====
// Input channel: one raw sample per axis.
`timescale 1ns / 1ps
interface jacs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_x;
  logic [15:0] raw_y;

  modport source (output valid, output raw_x, output raw_y, input ready);
  modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

// ===== rtl/jacs_out_if.sv =====
// Result channel: one calibrated position per axis.
`timescale 1ns / 1ps
interface jacs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pos_x;
  logic [15:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

// ===== rtl/jacs_axis_pipe.sv =====
// Datapath of one axis: segment select, scaled numerator, pipelined divider, output register.
`timescale 1ns / 1ps
module jacs_axis_pipe
  import jacs_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [15:0]      sample,
  input  logic [CFG_W-1:0] lo_cal,
  input  logic [CFG_W-1:0] mid_cal,
  input  logic [CFG_W-1:0] hi_cal,
  output logic [POS_W-1:0] pos
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned NW = SB + QBITS;

  logic [SB-1:0] s_m, lo_m, mid_m, hi_m;
  seg_t          seg_nxt;
  logic [SB-1:0] d_nxt, dv_nxt;

  seg_t          seg1_r;
  logic [SB-1:0] d1_r, dv1_r;

  logic [NW-1:0] num_nxt;

  logic [SB-1:0]    rem_r [QBITS];
  logic [QBITS-1:0] num_r [QBITS];
  logic [SB-1:0]    div_r [QBITS];
  logic [QBITS-1:0] quo_r [QBITS+1];
  seg_t             seg_r [QBITS+1];

  logic [POS_W-1:0] pos_nxt, pos_r;

  always_comb begin
    s_m   = sample[SB-1:0];
    lo_m  = lo_cal[SB-1:0];
    mid_m = mid_cal[SB-1:0];
    hi_m  = hi_cal[SB-1:0];
    priority if (s_m <= lo_m) begin
      seg_nxt = SEG_ZERO;
      d_nxt   = '0;
      dv_nxt  = '0;
    end else if (s_m >= hi_m) begin
      seg_nxt = SEG_FULL;
      d_nxt   = '0;
      dv_nxt  = '0;
    end else if (s_m <= mid_m) begin
      seg_nxt = SEG_LOW;
      d_nxt   = s_m - lo_m;
      dv_nxt  = mid_m - lo_m;
    end else begin
      seg_nxt = SEG_HIGH;
      d_nxt   = s_m - mid_m;
      dv_nxt  = hi_m - mid_m;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seg1_r <= seg_nxt;
      d1_r   <= d_nxt;
      dv1_r  <= dv_nxt;
    end
  end

  // low segment scales by 2^15 - 1, high segment by 2^15
  always_comb begin
    if (seg1_r == SEG_LOW) begin
      num_nxt = {d1_r, {QBITS{1'b0}}} - {{QBITS{1'b0}}, d1_r};
    end else begin
      num_nxt = {d1_r, {QBITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= num_nxt[NW-1:QBITS];
      num_r[0] <= num_nxt[QBITS-1:0];
      div_r[0] <= dv1_r;
      quo_r[0] <= '0;
      seg_r[0] <= seg1_r;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    logic [SB+1:0] trial;
    logic          take;
    logic [SB-1:0] rem_nxt;

    always_comb begin
      trial   = {1'b0, rem_r[k], num_r[k][QBITS-1]} - {2'b00, div_r[k]};
      take    = !trial[SB+1];
      rem_nxt = take ? trial[SB-1:0] : {rem_r[k][SB-2:0], num_r[k][QBITS-1]};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        quo_r[k+1] <= {quo_r[k][QBITS-2:0], take};
        seg_r[k+1] <= seg_r[k];
      end
    end

    if (k < QBITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k+1] <= rem_nxt;
          num_r[k+1] <= {num_r[k][QBITS-2:0], 1'b0};
          div_r[k+1] <= div_r[k];
        end
      end
    end else begin : g_last
      logic unused_rem;
      assign unused_rem = ^rem_nxt;
    end
  end

  always_comb begin
    unique case (seg_r[QBITS])
      SEG_ZERO: pos_nxt = POS_ZERO;
      SEG_FULL: pos_nxt = POS_FULL;
      SEG_LOW:  pos_nxt = {{(POS_W-QBITS){1'b0}}, quo_r[QBITS]};
      SEG_HIGH: pos_nxt = POS_CENTER + {{(POS_W-QBITS){1'b0}}, quo_r[QBITS]};
      default:  pos_nxt = POS_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r <= pos_nxt;
    end
  end

  assign pos = pos_r;

endmodule

// ===== rtl/joystick_axis_calibrated_scaler_unit.sv =====
// Top level of the joystick axis calibrated scaler: calibration registers and stage valids.
//
//   port       dir    carries
//   in_chan    sink   raw_x, raw_y
//   out_chan   source pos_x, pos_y
//   cfg_*      in     calibration register writes (index 0..5)
//
// One sample pair enters every cycle unless a held result stalls the pipeline; each result
// passes the 15-stage restoring divider, one quotient bit per stage, before the output register.
// Synchronous active-low reset clears the stage valids and loads default calibration.
// A held result stalls every stage at once; nothing is dropped or repeated.
`timescale 1ns / 1ps
module joystick_axis_calibrated_scaler_unit
  import jacs_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  jacs_in_if.sink              in_chan,
  jacs_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0] x_lo_r, x_mid_r, x_hi_r;
  logic [CFG_W-1:0] y_lo_r, y_mid_r, y_hi_r;

  logic           adv;
  logic [LAT-1:0] vld_r;
  logic           out_valid_r;

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_lo_r  <= RST_LOW;
      x_mid_r <= RST_MID;
      x_hi_r  <= RST_HIGH;
      y_lo_r  <= RST_LOW;
      y_mid_r <= RST_MID;
      y_hi_r  <= RST_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_X_LOW:  x_lo_r  <= cfg_wdata;
        CFG_X_MID:  x_mid_r <= cfg_wdata;
        CFG_X_HIGH: x_hi_r  <= cfg_wdata;
        CFG_Y_LOW:  y_lo_r  <= cfg_wdata;
        CFG_Y_MID:  y_mid_r <= cfg_wdata;
        CFG_Y_HIGH: y_hi_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-2:0], in_chan.valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  jacs_axis_pipe #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_axis_x (
    .clk     (clk),
    .adv     (adv),
    .sample  (in_chan.raw_x),
    .lo_cal  (x_lo_r),
    .mid_cal (x_mid_r),
    .hi_cal  (x_hi_r),
    .pos     (out_chan.pos_x)
  );

  jacs_axis_pipe #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_axis_y (
    .clk     (clk),
    .adv     (adv),
    .sample  (in_chan.raw_y),
    .lo_cal  (y_lo_r),
    .mid_cal (y_mid_r),
    .hi_cal  (y_hi_r),
    .pos     (out_chan.pos_y)
  );

  assign out_chan.valid = out_valid_r;

`ifndef SYNTHESIS
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> vld_r[0])
    else $error("accepted transfer missing from first stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && out_valid_r)
    else $error("stage valids moved during stall");

  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(vld_r[LAT-1]))
    else $error("result appeared without a transfer in the last stage");

  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[LAT-2] |=> vld_r[LAT-1])
    else $error("valid lost between stages");
`endif

endmodule

// ===== tb/jacs_checker.sv =====
// Checker for the joystick axis calibrated scaler: mirrors calibration, predicts and compares.
`timescale 1ns / 1ps
module jacs_checker
  import jacs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  jacs_in_if                   in_mon,
  jacs_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);

  localparam longint unsigned LOW_SCALE  = 32767;
  localparam longint unsigned HIGH_SCALE = 32768;
  localparam int              MAX_SHOWN  = 10;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } position_t;

  logic [CFG_W-1:0] x_low, x_mid, x_high;
  logic [CFG_W-1:0] y_low, y_mid, y_high;
  position_t        positions_due[$];
  position_t        got, due;
  int               fail_total = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [POS_W-1:0] axis_position(input logic [CFG_W-1:0] s,
                                                      input logic [CFG_W-1:0] lo,
                                                      input logic [CFG_W-1:0] mid,
                                                      input logic [CFG_W-1:0] hi);
    longint unsigned offset;
    longint unsigned scaled;
    if (s <= lo) return POS_ZERO;
    if (s >= hi) return POS_FULL;
    if (s <= mid) begin
      offset = s - lo;
      scaled = offset * LOW_SCALE;
      return POS_W'(scaled / (mid - lo));
    end
    offset = s - mid;
    scaled = offset * HIGH_SCALE;
    return POS_CENTER + POS_W'(scaled / (hi - mid));
  endfunction

  task automatic report_field(input string field, input logic [POS_W-1:0] exp_val,
                              input logic [POS_W-1:0] act_val);
    if (act_val !== exp_val) begin
      fail_total++;
      if (fail_total <= MAX_SHOWN)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      x_low  = RST_LOW;
      x_mid  = RST_MID;
      x_high = RST_HIGH;
      y_low  = RST_LOW;
      y_mid  = RST_MID;
      y_high = RST_HIGH;
      positions_due.delete();
      outstanding <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{pos_x: out_mon.pos_x, pos_y: out_mon.pos_y};
        if (positions_due.size() == 0) begin
          fail_total++;
          if (fail_total <= MAX_SHOWN)
            $display("%0t: unexpected transfer: pos_x %0d pos_y %0d", $realtime,
                     got.pos_x, got.pos_y);
        end else begin
          due = positions_due.pop_front();
          report_field("pos_x", due.pos_x, got.pos_x);
          report_field("pos_y", due.pos_y, got.pos_y);
        end
      end
      if (in_mon.valid && in_mon.ready)
        positions_due.push_back('{pos_x: axis_position(in_mon.raw_x, x_low, x_mid, x_high),
                                  pos_y: axis_position(in_mon.raw_y, y_low, y_mid, y_high)});
      if (cfg_we) begin
        case (cfg_idx)
          CFG_X_LOW:  x_low  = cfg_wdata;
          CFG_X_MID:  x_mid  = cfg_wdata;
          CFG_X_HIGH: x_high = cfg_wdata;
          CFG_Y_LOW:  y_low  = cfg_wdata;
          CFG_Y_MID:  y_mid  = cfg_wdata;
          CFG_Y_HIGH: y_high = cfg_wdata;
          default: ;
        endcase
      end
      outstanding <= positions_due.size();
    end
    mismatches <= fail_total;
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the joystick axis calibrated scaler: stimulus, calibration phases, verdict.
`timescale 1ns / 1ps
module tb;
  import jacs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam int ROUNDS          = 8;
  localparam int ITEMS_PER_ROUND = 150;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;
  typedef enum {CAL_SORTED, CAL_FULL, CAL_FLAT, CAL_SCRAMBLED, CAL_NARROW, CAL_PINCHED}
    cal_shape_t;

  typedef struct packed {
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] mid;
    logic [CFG_W-1:0] hi;
  } axis_cal_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   gap_pct   = 0;
  int                   stall_pct = 0;
  int                   mismatches;
  int                   outstanding;
  axis_cal_t            cal_x, cal_y;

  jacs_in_if  in_chan ();
  jacs_out_if out_chan ();

  joystick_axis_calibrated_scaler_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  jacs_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #20_000_000;
    $display("joystick_axis_calibrated_scaler_unit test failed");
    $finish;
  end

  task automatic set_idling(input idling_t mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        gap_pct   = 85;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct   = 0;
        stall_pct = 85;
      end
      default: begin
        gap_pct   = 22;
        stall_pct = 22;
      end
    endcase
  endtask

  task automatic send_sample(input logic [15:0] x, input logic [15:0] y);
    while ($urandom_range(99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.raw_x <= x;
    in_chan.raw_y <= y;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // hold until every expected transfer has arrived, then let the pipeline settle
  task automatic drain;
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LAT + 2) @(posedge clk);
  endtask

  task automatic load_calibration(input axis_cal_t cx, input axis_cal_t cy);
    logic [CFG_IDX_W-1:0] idx[8];
    logic [CFG_W-1:0]     val[8];
    idx = '{CFG_X_LOW, CFG_X_MID, CFG_X_HIGH, CFG_Y_LOW, CFG_Y_MID, CFG_Y_HIGH,
            CFG_SPARE_A, CFG_SPARE_B};
    val = '{cx.lo, cx.mid, cx.hi, cy.lo, cy.mid, cy.hi, 16'($urandom), 16'($urandom)};
    foreach (idx[i]) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic axis_cal_t shape_cal(input cal_shape_t shape);
    logic [CFG_W-1:0] a, b, c, t;
    axis_cal_t        r;
    a = 16'($urandom);
    b = 16'($urandom);
    c = 16'($urandom);
    if (a > b) begin t = a; a = b; b = t; end
    if (b > c) begin t = b; b = c; c = t; end
    if (a > b) begin t = a; a = b; b = t; end
    case (shape)
      CAL_SORTED: r = '{a, b, c};
      CAL_FULL:   r = '{16'd0, b, 16'hFFFF};
      CAL_FLAT: begin
        case ($urandom_range(2))
          0:       t = 16'd0;
          1:       t = 16'hFFFF;
          default: t = b;
        endcase
        r = '{t, t, t};
      end
      CAL_SCRAMBLED: r = '{16'($urandom), 16'($urandom), 16'($urandom)};
      CAL_NARROW: begin
        t = 16'($urandom_range(65533));
        r = '{t, t + 16'd1, t + 16'd2};
      end
      default: r = $urandom_range(1) ? axis_cal_t'{a, a, c} : axis_cal_t'{a, c, c};
    endcase
    return r;
  endfunction

  function automatic logic [15:0] pick_sample(input axis_cal_t c);
    logic [15:0] anchor, lo_b, hi_b;
    case ($urandom_range(2))
      0:       anchor = c.lo;
      1:       anchor = c.mid;
      default: anchor = c.hi;
    endcase
    lo_b = (c.lo < c.hi) ? c.lo : c.hi;
    hi_b = (c.lo < c.hi) ? c.hi : c.lo;
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return anchor + 16'($urandom_range(6)) - 16'd3;
      2:       return anchor + 16'($urandom_range(600)) - 16'd300;
      default: return 16'($urandom_range(hi_b, lo_b));
    endcase
  endfunction

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_X_LOW;
    cfg_wdata      = '0;
    in_chan.valid  = 1'b0;
    in_chan.raw_x  = '0;
    in_chan.raw_y  = '0;
    out_chan.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration: around each calibration point and the range ends
    set_idling(IDLE_NONE);
    send_sample(16'd0, 16'd65535);
    send_sample(16'd32768, 16'd32768);
    send_sample(16'd32769, 16'd49151);
    send_sample(16'd49152, 16'd49153);
    send_sample(16'd65534, 16'd65535);
    send_sample(16'hAAAA, 16'h5555);
    send_sample(16'h5555, 16'hAAAA);
    drain;

    // empty lower segment on x; high below low with mid above on y
    load_calibration(axis_cal_t'{16'd1000, 16'd1000, 16'd3000},
                     axis_cal_t'{16'd5000, 16'd9000, 16'd2000});
    send_sample(16'd1000, 16'd5000);
    send_sample(16'd1001, 16'd5001);
    send_sample(16'd2999, 16'd4000);
    send_sample(16'd3000, 16'd9000);
    drain;

    // widest segments
    load_calibration(axis_cal_t'{16'd0, 16'd65535, 16'd65535},
                     axis_cal_t'{16'd0, 16'd1, 16'd65535});
    send_sample(16'd65534, 16'd65534);
    send_sample(16'd1, 16'd1);
    send_sample(16'd65535, 16'd0);
    send_sample(16'd0, 16'd2);
    drain;

    // all points equal: low test wins over high
    load_calibration(axis_cal_t'{16'd0, 16'd0, 16'd0},
                     axis_cal_t'{16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_sample(16'd0, 16'd65535);
    send_sample(16'd1, 16'd65534);
    drain;

    for (int r = 0; r < ROUNDS; r++) begin
      cal_x = shape_cal(cal_shape_t'(r % 6));
      cal_y = shape_cal(cal_shape_t'((r + 3) % 6));
      load_calibration(cal_x, cal_y);
      set_idling(idling_t'(r % 4));
      repeat (ITEMS_PER_ROUND) send_sample(pick_sample(cal_x), pick_sample(cal_y));
      drain;
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("joystick_axis_calibrated_scaler_unit test passed");
    end else begin
      $display("joystick_axis_calibrated_scaler_unit test failed");
    end
    $finish;
  end

endmodule
